// ----- src/lfr_pkg.sv -----
// shared types and constants of the lru frame replacer
package lfr_pkg;

	localparam int NUM_FRAMES_DEF = 64;
	localparam int CMD_W          = 2;
	localparam int FRAME_W        = 6;
	localparam int COUNT_W        = 7;

	localparam logic [CMD_W-1:0] CMD_VICTIM = 2'd0;
	localparam logic [CMD_W-1:0] CMD_PIN    = 2'd1;
	localparam logic [CMD_W-1:0] CMD_UNPIN  = 2'd2;

	typedef logic [FRAME_W-1:0] frame_num_t;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		frame_num_t       frame_number;
	} cmd_item_t;

	typedef struct packed {
		logic               evicted;
		frame_num_t         victim_frame;
		logic [COUNT_W-1:0] evictable_count;
	} res_item_t;

	// broadcast from the controller to every cell of the recency row
	typedef struct packed {
		logic       shift_all;
		logic       pin;
		logic       append;
		frame_num_t frame;
	} cell_ctl_t;

endpackage

// ----- src/lfr_stream_if.sv -----
// valid/ready channel carrying one item per handshake
interface lfr_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- src/lfr_cell.sv -----
// one slot of the recency row: holds a frame id and its valid bit
module lfr_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  lfr_pkg::cell_ctl_t ctl,
	input  logic               left_vld,
	input  logic               right_vld,
	input  lfr_pkg::frame_num_t right_id,
	output logic               vld,
	output lfr_pkg::frame_num_t id
);
	import lfr_pkg::*;

	logic       vld_q;
	frame_num_t id_q;
	logic       vld_nxt;
	frame_num_t id_nxt;

	always_comb begin
		vld_nxt = vld_q;
		id_nxt  = id_q;
		if (ctl.shift_all) begin
			vld_nxt = right_vld;
			id_nxt  = right_id;
		end else if (ctl.pin && vld_q && (id_q == ctl.frame)) begin
			vld_nxt = 1'b0;
		end else if (ctl.append && !vld_q && left_vld) begin
			vld_nxt = 1'b1;
			id_nxt  = ctl.frame;
		end else if (!vld_q && right_vld) begin
			// hole here: pull the neighbor down one slot
			vld_nxt = 1'b1;
			id_nxt  = right_id;
		end else if (vld_q && !left_vld) begin
			// content handed to the left, hole moves up
			vld_nxt = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= vld_nxt;
		end
	end

	always_ff @(posedge clk) begin
		id_q <= id_nxt;
	end

	assign vld = vld_q;
	assign id  = id_q;

endmodule

// ----- src/lru_frame_replacer.sv -----
// top level: least-recently-unpinned frame replacer built on a row of cells
//
//   channel  dir  fields                                         handshake
//   cmd      in   command, frame_number                          valid/ready
//   res      out  evicted, victim_frame, evictable_count         valid/ready
//
// victim and unpin leave the row compact; a pin clears its cell, and the hole
// then walks up the cell row to the tail, entry by entry, while items are held off.
// the longest walk follows a pin of the oldest frame.
// reset clears the cell valid bits and the length at once.
// cmd.ready is low while a hole is in the row or a result waits untaken.
module lru_frame_replacer #(
	parameter int NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
	input logic         clk,
	input logic         arst_n,
	lfr_stream_if.sink   cmd,
	lfr_stream_if.source res
);
	import lfr_pkg::*;

	localparam int CNT_W = $clog2(NUM_FRAMES + 1);

	logic [NUM_FRAMES-1:0] cell_vld;
	frame_num_t            cell_id [NUM_FRAMES];
	logic [CNT_W-1:0]      len_q;
	logic [CNT_W-1:0]      len_nxt;
	logic                  res_vld_q;
	res_item_t             res_data_q;
	res_item_t             res_nxt;
	cell_ctl_t             ctl;

	logic                  hole_any;
	logic [NUM_FRAMES-1:0] hole;
	logic [NUM_FRAMES-1:0] hit;
	logic                  accept;
	logic [31:0]           fid_wide;
	logic                  fid_ok;
	logic                  is_listed;
	logic                  not_empty;

	assign fid_wide  = 32'(cmd.payload.frame_number);
	assign fid_ok    = fid_wide < 32'(NUM_FRAMES);
	// the row is compact whenever an item is taken, so a match means listed
	assign is_listed = |hit;
	assign not_empty = (len_q != '0);

	assign cmd.ready = !hole_any && (!res_vld_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;

	always_comb begin
		ctl           = '0;
		ctl.frame     = cmd.payload.frame_number;
		len_nxt       = len_q;
		res_nxt       = '0;
		if (accept) begin
			unique case (cmd.payload.command)
				CMD_VICTIM: begin
					if (not_empty) begin
						ctl.shift_all        = 1'b1;
						len_nxt              = len_q - 1'b1;
						res_nxt.evicted      = 1'b1;
						res_nxt.victim_frame = cell_id[0];
					end
				end
				CMD_PIN: begin
					if (fid_ok && is_listed) begin
						ctl.pin = 1'b1;
						len_nxt = len_q - 1'b1;
					end
				end
				CMD_UNPIN: begin
					if (fid_ok && !is_listed && (len_q < CNT_W'(NUM_FRAMES))) begin
						ctl.append = 1'b1;
						len_nxt    = len_q + 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
		res_nxt.evictable_count = COUNT_W'(len_nxt);
	end

	// recency row, index 0 holds the least recent frame
	for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
		logic       left_v;
		logic       right_v;
		frame_num_t right_i;

		if (k == 0) begin : g_head
			assign left_v = 1'b1;
		end else begin : g_mid
			assign left_v = cell_vld[k-1];
		end

		if (k == NUM_FRAMES - 1) begin : g_tail
			assign right_v = 1'b0;
			assign right_i = '0;
			assign hole[k] = 1'b0;
		end else begin : g_body
			assign right_v = cell_vld[k+1];
			assign right_i = cell_id[k+1];
			assign hole[k] = !cell_vld[k] && cell_vld[k+1];
		end

		assign hit[k] = cell_vld[k] && (cell_id[k] == cmd.payload.frame_number);

		lfr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.left_vld  (left_v),
			.right_vld (right_v),
			.right_id  (right_i),
			.vld       (cell_vld[k]),
			.id        (cell_id[k])
		);
	end

	assign hole_any = |hole;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			res_vld_q <= 1'b0;
		end else begin
			len_q <= len_nxt;
			if (accept) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_data_q <= res_nxt;
		end
	end

	assign res.valid   = res_vld_q;
	assign res.payload = res_data_q;

`ifndef NO_ASSERTIONS
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> res.valid)
		else $error("accepted item gave no result");

	a_no_accept_with_hole: assert property (@(posedge clk) disable iff (!arst_n)
		hole_any |-> !cmd.ready)
		else $error("item taken while the row was compacting");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= CNT_W'(NUM_FRAMES))
		else $error("list length beyond frame count");

	a_no_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.payload.evicted) |-> (res.payload.victim_frame == '0))
		else $error("victim id set without eviction");

	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(!hole_any && not_empty) |-> cell_vld[0])
		else $error("nonempty list with empty head cell");
`endif

endmodule
